>>> hw/rtl/ntps_pkg.sv
package ntps_pkg;

  // Default sizes handed to the top level.
  localparam int HISTORY_DEPTH_DEF = 256;
  localparam int POSE_WIDTH_DEF    = 32;

  // Fixed field widths.
  localparam int TIME_W    = 62;
  localparam int SEC_W     = 32;
  localparam int NANO_W    = 30;
  localparam int GAP_CFG_W = 40;
  localparam int LIMIT_W   = 9;
  localparam int CFG_IDX_W = 2;

  localparam logic [NANO_W-1:0] NS_PER_SEC = 30'd1000000000;

  // Register reset values: 0.1 s gap threshold, 200 entries kept.
  localparam logic [GAP_CFG_W-1:0] MAX_GAP_RST = 40'd100000000;
  localparam logic [LIMIT_W-1:0]   LIMIT_RST   = 9'd200;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_MAX_GAP       = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HISTORY_LIMIT = 2'd1;

  typedef enum logic [1:0] {
    STATUS_MATCHED = 2'd0,
    STATUS_EMPTY   = 2'd1,
    STATUS_TOO_FAR = 2'd2
  } status_t;

  // Control travelling alongside each history word read during a scan.
  typedef struct packed {
    logic valid;
    logic first;
  } scan_ctl_t;

endpackage

>>> hw/rtl/nearest_timestamp_pose_sync.sv
// Nearest-timestamp pose synchroniser. An odometry word (req_type 0) is
// appended to a ring of up to history_limit poses; it gives no result. A
// scan query (req_type 1) walks the stored entries from oldest to newest
// through one shared gap/compare unit at one entry per cycle, set by the
// single read port of the history memory. The block is busy for the whole
// of an item and takes no start meanwhile. Each query gives exactly one
// result word, shown for one cycle with done high; the receiver cannot
// stall it. Status is matched, history empty, or gap beyond max_gap_ns; a
// too-far result still carries the nearest pose. Times are integer ns.
module nearest_timestamp_pose_sync #(
  parameter int HISTORY_DEPTH = ntps_pkg::HISTORY_DEPTH_DEF,
  parameter int POSE_WIDTH    = ntps_pkg::POSE_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic                                req_type,
  input  logic [ntps_pkg::SEC_W-1:0]          stamp_seconds,
  input  logic [ntps_pkg::NANO_W-1:0]         stamp_nanos,
  input  logic signed [POSE_WIDTH-1:0]        pose_x,
  input  logic signed [POSE_WIDTH-1:0]        pose_y,
  input  logic signed [POSE_WIDTH-1:0]        pose_heading,
  input  logic                                cfg_we,
  input  logic [ntps_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ntps_pkg::GAP_CFG_W-1:0]      cfg_data,
  output logic                                done,
  output logic [1:0]                          status,
  output logic signed [POSE_WIDTH-1:0]        match_x,
  output logic signed [POSE_WIDTH-1:0]        match_y,
  output logic signed [POSE_WIDTH-1:0]        match_heading,
  output logic [ntps_pkg::TIME_W-1:0]         match_time_ns,
  output logic [ntps_pkg::TIME_W-1:0]         time_gap_ns
);

  localparam int TW    = ntps_pkg::TIME_W;
  localparam int IDX_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int CNT_W = $clog2(HISTORY_DEPTH + 1);
  localparam int SUM_W = CNT_W + 1;
  localparam int LIM_W = ((CNT_W > ntps_pkg::LIMIT_W) ? CNT_W : ntps_pkg::LIMIT_W) + 1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_ADD,
    ST_WRITE,
    ST_SCAN,
    ST_DRAIN,
    ST_FINISH
  } state_t;

  state_t state;

  // Configuration registers.
  logic [ntps_pkg::GAP_CFG_W-1:0] max_gap;
  logic [ntps_pkg::LIMIT_W-1:0]   history_limit;

  // Latched item.
  logic                        req_q;
  logic [ntps_pkg::SEC_W-1:0]  sec_q;
  logic [ntps_pkg::NANO_W-1:0] nanos_q;
  logic signed [POSE_WIDTH-1:0] x_q;
  logic signed [POSE_WIDTH-1:0] y_q;
  logic signed [POSE_WIDTH-1:0] heading_q;
  logic [TW-1:0]               prod;
  logic [TW-1:0]               stamp;

  // Ring pointers and scan control.
  logic [IDX_W-1:0]    oldest;
  logic [CNT_W-1:0]    count;
  logic [IDX_W-1:0]    rd_ptr;
  logic [CNT_W-1:0]    scan_k;
  ntps_pkg::scan_ctl_t rd_ctl;

  // Ring arithmetic.
  logic [SUM_W-1:0] slot_sum;
  logic [IDX_W-1:0] slot;
  logic [LIM_W-1:0] lim_wide;
  logic [CNT_W-1:0] limit_eff;
  logic [SUM_W-1:0] n_next;
  logic             evict;
  logic [SUM_W-1:0] adv_sum;
  logic [IDX_W-1:0] oldest_adv;
  logic [IDX_W-1:0] rd_ptr_inc;
  logic             mem_we;

  // History read data and best match.
  logic [TW-1:0]                rd_time;
  logic signed [POSE_WIDTH-1:0] rd_x;
  logic signed [POSE_WIDTH-1:0] rd_y;
  logic signed [POSE_WIDTH-1:0] rd_heading;
  logic                         gap_active;
  logic [TW-1:0]                best_gap;
  logic [TW-1:0]                best_time;
  logic signed [POSE_WIDTH-1:0] best_x;
  logic signed [POSE_WIDTH-1:0] best_y;
  logic signed [POSE_WIDTH-1:0] best_heading;

  // Slot for a new entry, effective limit and the eviction step.
  always_comb begin
    slot_sum = SUM_W'(oldest) + SUM_W'(count);
    slot     = (slot_sum >= SUM_W'(HISTORY_DEPTH)) ?
               IDX_W'(slot_sum - SUM_W'(HISTORY_DEPTH)) : IDX_W'(slot_sum);
    lim_wide = LIM_W'(history_limit);
    if (lim_wide == '0) begin
      limit_eff = CNT_W'(1);
    end else if (lim_wide > LIM_W'(HISTORY_DEPTH)) begin
      limit_eff = CNT_W'(HISTORY_DEPTH);
    end else begin
      limit_eff = CNT_W'(lim_wide);
    end
    n_next     = SUM_W'(count) + SUM_W'(1);
    evict      = n_next > SUM_W'(limit_eff);
    adv_sum    = SUM_W'(oldest) + (n_next - SUM_W'(limit_eff));
    oldest_adv = (adv_sum >= SUM_W'(HISTORY_DEPTH)) ?
                 IDX_W'(adv_sum - SUM_W'(HISTORY_DEPTH)) : IDX_W'(adv_sum);
    rd_ptr_inc = (rd_ptr == IDX_W'(HISTORY_DEPTH - 1)) ? '0 : rd_ptr + IDX_W'(1);
    mem_we     = (state == ST_WRITE);
  end

  assign busy = (state != ST_IDLE);

  // Sequencer, ring pointers, configuration and result word.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      done          <= 1'b0;
      oldest        <= '0;
      count         <= '0;
      rd_ctl        <= '0;
      max_gap       <= ntps_pkg::MAX_GAP_RST;
      history_limit <= ntps_pkg::LIMIT_RST;
    end else begin
      done         <= 1'b0;
      rd_ctl.valid <= 1'b0;
      rd_ctl.first <= 1'b0;

      if (cfg_we) begin
        unique case (cfg_index)
          ntps_pkg::REG_MAX_GAP:       max_gap <= cfg_data;
          ntps_pkg::REG_HISTORY_LIMIT: history_limit <= cfg_data[ntps_pkg::LIMIT_W-1:0];
          default: ;
        endcase
      end

      unique case (state)
        ST_IDLE: begin
          if (start) begin
            req_q     <= req_type;
            sec_q     <= stamp_seconds;
            nanos_q   <= stamp_nanos;
            x_q       <= pose_x;
            y_q       <= pose_y;
            heading_q <= pose_heading;
            state     <= ST_MUL;
          end
        end
        ST_MUL: begin
          prod  <= TW'(sec_q) * TW'(ntps_pkg::NS_PER_SEC);
          state <= ST_ADD;
        end
        ST_ADD: begin
          stamp  <= prod + TW'(nanos_q);
          rd_ptr <= oldest;
          scan_k <= '0;
          if (!req_q) begin
            state <= ST_WRITE;
          end else if (count == '0) begin
            status        <= ntps_pkg::STATUS_EMPTY;
            match_x       <= '0;
            match_y       <= '0;
            match_heading <= '0;
            match_time_ns <= '0;
            time_gap_ns   <= '0;
            done          <= 1'b1;
            state         <= ST_IDLE;
          end else begin
            state <= ST_SCAN;
          end
        end
        ST_WRITE: begin
          if (evict) begin
            oldest <= oldest_adv;
            count  <= limit_eff;
          end else begin
            count  <= CNT_W'(n_next);
          end
          state <= ST_IDLE;
        end
        ST_SCAN: begin
          rd_ctl.valid <= 1'b1;
          rd_ctl.first <= (scan_k == '0);
          rd_ptr       <= rd_ptr_inc;
          scan_k       <= scan_k + CNT_W'(1);
          if (scan_k == count - CNT_W'(1)) begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (!rd_ctl.valid && !gap_active) begin
            state <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          status        <= (best_gap > TW'(max_gap)) ? ntps_pkg::STATUS_TOO_FAR
                                                     : ntps_pkg::STATUS_MATCHED;
          match_x       <= best_x;
          match_y       <= best_y;
          match_heading <= best_heading;
          match_time_ns <= best_time;
          time_gap_ns   <= best_gap;
          done          <= 1'b1;
          state         <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  ntps_hist_mem #(
    .DEPTH  (HISTORY_DEPTH),
    .POSE_W (POSE_WIDTH),
    .IDX_W  (IDX_W)
  ) u_hist_mem (
    .clk      (clk),
    .we       (mem_we),
    .waddr    (slot),
    .wtime    (stamp),
    .wx       (x_q),
    .wy       (y_q),
    .wheading (heading_q),
    .raddr    (rd_ptr),
    .rtime    (rd_time),
    .rx       (rd_x),
    .ry       (rd_y),
    .rheading (rd_heading)
  );

  ntps_gap_unit #(
    .POSE_W (POSE_WIDTH)
  ) u_gap_unit (
    .clk          (clk),
    .rst          (rst),
    .ctl          (rd_ctl),
    .q_time       (stamp),
    .e_time       (rd_time),
    .e_x          (rd_x),
    .e_y          (rd_y),
    .e_heading    (rd_heading),
    .active       (gap_active),
    .best_gap     (best_gap),
    .best_time    (best_time),
    .best_x       (best_x),
    .best_y       (best_y),
    .best_heading (best_heading)
  );

endmodule

>>> hw/rtl/ntps_hist_mem.sv
module ntps_hist_mem #(
  parameter int DEPTH  = ntps_pkg::HISTORY_DEPTH_DEF,
  parameter int POSE_W = ntps_pkg::POSE_WIDTH_DEF,
  parameter int IDX_W  = 8
) (
  input  logic                            clk,
  input  logic                            we,
  input  logic [IDX_W-1:0]                waddr,
  input  logic [ntps_pkg::TIME_W-1:0]     wtime,
  input  logic signed [POSE_W-1:0]        wx,
  input  logic signed [POSE_W-1:0]        wy,
  input  logic signed [POSE_W-1:0]        wheading,
  input  logic [IDX_W-1:0]                raddr,
  output logic [ntps_pkg::TIME_W-1:0]     rtime,
  output logic signed [POSE_W-1:0]        rx,
  output logic signed [POSE_W-1:0]        ry,
  output logic signed [POSE_W-1:0]        rheading
);

  logic [ntps_pkg::TIME_W-1:0] time_mem    [DEPTH];
  logic signed [POSE_W-1:0]    x_mem       [DEPTH];
  logic signed [POSE_W-1:0]    y_mem       [DEPTH];
  logic signed [POSE_W-1:0]    heading_mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      time_mem[waddr]    <= wtime;
      x_mem[waddr]       <= wx;
      y_mem[waddr]       <= wy;
      heading_mem[waddr] <= wheading;
    end
    rtime    <= time_mem[raddr];
    rx       <= x_mem[raddr];
    ry       <= y_mem[raddr];
    rheading <= heading_mem[raddr];
  end

endmodule

>>> hw/rtl/ntps_gap_unit.sv
module ntps_gap_unit #(
  parameter int POSE_W = ntps_pkg::POSE_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  ntps_pkg::scan_ctl_t          ctl,
  input  logic [ntps_pkg::TIME_W-1:0]  q_time,
  input  logic [ntps_pkg::TIME_W-1:0]  e_time,
  input  logic signed [POSE_W-1:0]     e_x,
  input  logic signed [POSE_W-1:0]     e_y,
  input  logic signed [POSE_W-1:0]     e_heading,
  output logic                         active,
  output logic [ntps_pkg::TIME_W-1:0]  best_gap,
  output logic [ntps_pkg::TIME_W-1:0]  best_time,
  output logic signed [POSE_W-1:0]     best_x,
  output logic signed [POSE_W-1:0]     best_y,
  output logic signed [POSE_W-1:0]     best_heading
);

  localparam int TW = ntps_pkg::TIME_W;

  logic [TW:0]   diff_fwd;
  logic [TW:0]   diff_rev;
  logic [TW-1:0] gap_abs;

  logic                 s1_vld;
  logic                 s1_first;
  logic [TW-1:0]        s1_gap;
  logic [TW-1:0]        s1_time;
  logic signed [POSE_W-1:0] s1_x;
  logic signed [POSE_W-1:0] s1_y;
  logic signed [POSE_W-1:0] s1_heading;

  // Both differences side by side; the borrow of the first picks the positive one.
  always_comb begin
    diff_fwd = {1'b0, e_time} - {1'b0, q_time};
    diff_rev = {1'b0, q_time} - {1'b0, e_time};
    gap_abs  = diff_fwd[TW] ? diff_rev[TW-1:0] : diff_fwd[TW-1:0];
  end

  // Stage one holds the absolute gap of the word just read.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
    end else begin
      s1_vld <= ctl.valid;
    end
    s1_first   <= ctl.first;
    s1_gap     <= gap_abs;
    s1_time    <= e_time;
    s1_x       <= e_x;
    s1_y       <= e_y;
    s1_heading <= e_heading;
  end

  // Stage two keeps the best so far; a strict compare lets the oldest win a tie.
  always_ff @(posedge clk) begin
    if (s1_vld && (s1_first || (s1_gap < best_gap))) begin
      best_gap     <= s1_gap;
      best_time    <= s1_time;
      best_x       <= s1_x;
      best_y       <= s1_y;
      best_heading <= s1_heading;
    end
  end

  assign active = s1_vld;

endmodule

>>> hw/rtl/ntps_checker.sv
module ntps_checker #(
  parameter int POSE_WIDTH = ntps_pkg::POSE_WIDTH_DEF
) (
  input logic                          clk,
  input logic                          rst,
  input logic                          start,
  input logic                          busy,
  input logic                          done,
  input logic [1:0]                    status,
  input logic signed [POSE_WIDTH-1:0]  match_x,
  input logic [ntps_pkg::TIME_W-1:0]   match_time_ns,
  input logic [ntps_pkg::TIME_W-1:0]   time_gap_ns
);

  // An accepted word always keeps the block busy in the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("block not busy after an accepted word");

  // A result only appears as the block comes back from work.
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(busy) && !busy))
    else $error("result word outside the end of an item");

  // Each query gives a single result word.
  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result word repeated");

  // An empty history reports zeroed fields.
  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    (done && (status == ntps_pkg::STATUS_EMPTY)) |->
      ((match_time_ns == '0) && (time_gap_ns == '0) && (match_x == '0)))
    else $error("empty history result carries data");

  // Reset leaves the block idle with no result.
  a_reset_idle: assert property (@(posedge clk)
    rst |=> (!busy && !done))
    else $error("block not idle after reset");

endmodule

bind nearest_timestamp_pose_sync ntps_checker #(
  .POSE_WIDTH (POSE_WIDTH)
) u_ntps_checker (
  .clk           (clk),
  .rst           (rst),
  .start         (start),
  .busy          (busy),
  .done          (done),
  .status        (status),
  .match_x       (match_x),
  .match_time_ns (match_time_ns),
  .time_gap_ns   (time_gap_ns)
);
